FILE: rtl/fac_pkg.sv
// Shared constants, codes and types of the frustum box and point culling block.
package fac_pkg;

  localparam int NumPlanes = 6;
  localparam int CoordW    = 32;
  localparam int FracW     = 16;
  localparam int FieldW    = 32;
  localparam int PlaneIdxW = 3;
  localparam int ProdW     = 2 * CoordW;
  localparam int DistW     = 2 * CoordW + 2;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpPoint = 2'd1,
    OpBox   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    VerdictInside    = 2'd0,
    VerdictOutside   = 2'd1,
    VerdictIntersect = 2'd2
  } verdict_e;

  typedef struct packed {
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic p_behind;
    logic n_behind;
  } cull_t;

endpackage

FILE: rtl/fac_if.sv
// Request and response channel interfaces of the culling block.
interface fac_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic [fac_pkg::PlaneIdxW-1:0]       plane_index;
  logic signed [fac_pkg::FieldW-1:0]   normal_x;
  logic signed [fac_pkg::FieldW-1:0]   normal_y;
  logic signed [fac_pkg::FieldW-1:0]   normal_z;
  logic signed [fac_pkg::FieldW-1:0]   plane_offset;
  logic signed [fac_pkg::FieldW-1:0]   low_x;
  logic signed [fac_pkg::FieldW-1:0]   low_y;
  logic signed [fac_pkg::FieldW-1:0]   low_z;
  logic signed [fac_pkg::FieldW-1:0]   high_x;
  logic signed [fac_pkg::FieldW-1:0]   high_y;
  logic signed [fac_pkg::FieldW-1:0]   high_z;

  modport source (
    output valid, operation, plane_index, normal_x, normal_y, normal_z, plane_offset,
           low_x, low_y, low_z, high_x, high_y, high_z,
    input  ready
  );
  modport sink (
    input  valid, operation, plane_index, normal_x, normal_y, normal_z, plane_offset,
           low_x, low_y, low_z, high_x, high_y, high_z,
    output ready
  );
endinterface

interface fac_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

FILE: rtl/fac_plane_eval.sv
// Three-stage signed distance evaluation of the near and far box corners against one plane.
module fac_plane_eval (
  input  logic             clk_i,
  input  logic             en_i,
  input  fac_pkg::plane_t  plane_i,
  input  fac_pkg::vec_t    lo_i,
  input  fac_pkg::vec_t    hi_i,
  output fac_pkg::cull_t   cull_o
);

  fac_pkg::vec_t pv, nv;

  logic signed [fac_pkg::ProdW-1:0]                px_q, py_q, pz_q;
  logic signed [fac_pkg::ProdW-1:0]                nx_q, ny_q, nz_q;
  logic signed [fac_pkg::CoordW+fac_pkg::FracW-1:0] d_q;
  logic signed [fac_pkg::DistW-1:0]                pa_q, pb_q, na_q, nb_q;
  logic signed [fac_pkg::DistW-1:0]                p_dist, n_dist;
  fac_pkg::cull_t                                  cull_q;

  // The far corner takes the high coordinate wherever the normal component is not negative.
  always_comb begin
    pv.x = plane_i.nx[fac_pkg::CoordW-1] ? lo_i.x : hi_i.x;
    pv.y = plane_i.ny[fac_pkg::CoordW-1] ? lo_i.y : hi_i.y;
    pv.z = plane_i.nz[fac_pkg::CoordW-1] ? lo_i.z : hi_i.z;
    nv.x = plane_i.nx[fac_pkg::CoordW-1] ? hi_i.x : lo_i.x;
    nv.y = plane_i.ny[fac_pkg::CoordW-1] ? hi_i.y : lo_i.y;
    nv.z = plane_i.nz[fac_pkg::CoordW-1] ? hi_i.z : lo_i.z;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= fac_pkg::ProdW'(plane_i.nx) * fac_pkg::ProdW'(pv.x);
      py_q <= fac_pkg::ProdW'(plane_i.ny) * fac_pkg::ProdW'(pv.y);
      pz_q <= fac_pkg::ProdW'(plane_i.nz) * fac_pkg::ProdW'(pv.z);
      nx_q <= fac_pkg::ProdW'(plane_i.nx) * fac_pkg::ProdW'(nv.x);
      ny_q <= fac_pkg::ProdW'(plane_i.ny) * fac_pkg::ProdW'(nv.y);
      nz_q <= fac_pkg::ProdW'(plane_i.nz) * fac_pkg::ProdW'(nv.z);
      d_q  <= {plane_i.d, fac_pkg::FracW'(0)};

      pa_q <= fac_pkg::DistW'(px_q) + fac_pkg::DistW'(py_q);
      pb_q <= fac_pkg::DistW'(pz_q) + fac_pkg::DistW'(d_q);
      na_q <= fac_pkg::DistW'(nx_q) + fac_pkg::DistW'(ny_q);
      nb_q <= fac_pkg::DistW'(nz_q) + fac_pkg::DistW'(d_q);

      cull_q.p_behind <= p_dist[fac_pkg::DistW-1];
      cull_q.n_behind <= n_dist[fac_pkg::DistW-1];
    end
  end

  assign p_dist = pa_q + pb_q;
  assign n_dist = na_q + nb_q;
  assign cull_o = cull_q;

endmodule

FILE: rtl/frustum_aabb_cull.sv
// Top level of the frustum culling block: plane table, pipeline control and verdict.
//
//   Channel  Direction  Carries
//   req_i    in         plane write, point test or box test request
//   rsp_o    out        one verdict for each point or box test
//
// One request enters per cycle while no response is held at the output. A test verdict
// passes products, two adder levels and the verdict register, one stage each, once taken.
// A plane write takes effect at once for every later test and gives no response.
// Reset clears the plane table and all valid bits; the pipeline then runs at once.
// A response held at the output freezes the whole pipeline, and req_i.ready drops.
module frustum_aabb_cull (
  input  logic              clk_i,
  input  logic              rst_ni,
  fac_req_if.sink           req_i,
  fac_rsp_if.source         rsp_o
);

  fac_pkg::plane_t  plane_q [fac_pkg::NumPlanes];
  fac_pkg::cull_t   cull [fac_pkg::NumPlanes];
  fac_pkg::vec_t    lo, hi;
  fac_pkg::op_e     op;
  fac_pkg::verdict_e verdict_d, verdict_q;
  logic             adv, accept, is_test, is_write;
  logic             v1_q, v2_q, v3_q, out_v_q;
  logic             any_p, any_n;

  assign adv         = !out_v_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign accept      = req_i.valid && adv;
  assign op          = fac_pkg::op_e'(req_i.operation);

  always_comb begin
    is_test  = 1'b0;
    is_write = 1'b0;
    case (op)
      fac_pkg::OpWrite: is_write = 1'b1;
      fac_pkg::OpPoint: is_test  = 1'b1;
      fac_pkg::OpBox:   is_test  = 1'b1;
      default: begin
        is_test  = 1'b0;
        is_write = 1'b0;
      end
    endcase
  end

  // A point is tested as a box whose two corners coincide.
  always_comb begin
    lo.x = req_i.low_x[fac_pkg::CoordW-1:0];
    lo.y = req_i.low_y[fac_pkg::CoordW-1:0];
    lo.z = req_i.low_z[fac_pkg::CoordW-1:0];
    if (op == fac_pkg::OpBox) begin
      hi.x = req_i.high_x[fac_pkg::CoordW-1:0];
      hi.y = req_i.high_y[fac_pkg::CoordW-1:0];
      hi.z = req_i.high_z[fac_pkg::CoordW-1:0];
    end else begin
      hi = lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
        plane_q[k] <= '0;
      end
    end else if (accept && is_write) begin
      for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
        if (req_i.plane_index == fac_pkg::PlaneIdxW'(k)) begin
          plane_q[k].nx <= req_i.normal_x[fac_pkg::CoordW-1:0];
          plane_q[k].ny <= req_i.normal_y[fac_pkg::CoordW-1:0];
          plane_q[k].nz <= req_i.normal_z[fac_pkg::CoordW-1:0];
          plane_q[k].d  <= req_i.plane_offset[fac_pkg::CoordW-1:0];
        end
      end
    end
  end

  for (genvar k = 0; k < fac_pkg::NumPlanes; k++) begin : g_plane
    fac_plane_eval u_eval (
      .clk_i   (clk_i),
      .en_i    (adv),
      .plane_i (plane_q[k]),
      .lo_i    (lo),
      .hi_i    (hi),
      .cull_o  (cull[k])
    );
  end

  always_comb begin
    any_p = 1'b0;
    any_n = 1'b0;
    for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
      any_p = any_p | cull[k].p_behind;
      any_n = any_n | cull[k].n_behind;
    end
    if (any_p) begin
      verdict_d = fac_pkg::VerdictOutside;
    end else if (any_n) begin
      verdict_d = fac_pkg::VerdictIntersect;
    end else begin
      verdict_d = fac_pkg::VerdictInside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= accept && is_test;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      verdict_q <= verdict_d;
    end
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.verdict = verdict_q;

`ifndef SYNTHESIS
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.verdict == fac_pkg::VerdictInside ||
                     rsp_o.verdict == fac_pkg::VerdictOutside ||
                     rsp_o.verdict == fac_pkg::VerdictIntersect))
    else $error("response carries an undefined verdict code");

  a_write_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write) |=> !v1_q)
    else $error("a plane write entered the test pipeline");

  a_stage_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> rsp_o.valid)
    else $error("a test in the last stage did not reach the output");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q) && $stable(verdict_q)))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of frustum_aabb_cull: plane writes, point and box tests, with stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic signed [31:0] Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Min = 32'sh8000_0000;
  localparam logic signed [31:0] One = 32'sh0001_0000;
  localparam int ItemsPerPhase = 500;

  typedef struct packed {
    logic [1:0]                    op;
    logic [fac_pkg::PlaneIdxW-1:0] idx;
    fac_pkg::plane_t               pl;
    fac_pkg::vec_t                 lo;
    fac_pkg::vec_t                 hi;
  } cull_req_t;

  class cull_checker;
    fac_pkg::plane_t   planes[fac_pkg::NumPlanes];
    fac_pkg::verdict_e verdicts_due[$];
    int unsigned       faults;

    function new();
      foreach (planes[k]) planes[k] = '0;
      faults = 0;
    endfunction

    // Exact signed distance at 66 bits; only its sign matters.
    function bit behind_plane(int k, fac_pkg::vec_t pt);
      logic signed [65:0] nx, ny, nz, d, px, py, pz, sdist;
      nx = planes[k].nx;
      ny = planes[k].ny;
      nz = planes[k].nz;
      d  = planes[k].d;
      px = pt.x;
      py = pt.y;
      pz = pt.z;
      sdist = nx * px + ny * py + nz * pz + (d <<< fac_pkg::FracW);
      return sdist[65];
    endfunction

    function void note_request(cull_req_t r);
      fac_pkg::verdict_e v;
      fac_pkg::vec_t     pv, nv;
      bit                any_out, any_cut;
      any_out = 0;
      any_cut = 0;
      if (r.op == fac_pkg::OpWrite) begin
        if (r.idx < fac_pkg::NumPlanes) planes[r.idx] = r.pl;
      end else if (r.op == fac_pkg::OpPoint) begin
        for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
          if (behind_plane(k, r.lo)) any_out = 1;
        end
        if (any_out) v = fac_pkg::VerdictOutside;
        else v = fac_pkg::VerdictInside;
        verdicts_due.push_back(v);
      end else if (r.op == fac_pkg::OpBox) begin
        for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
          pv.x = (planes[k].nx >= 0) ? r.hi.x : r.lo.x;
          pv.y = (planes[k].ny >= 0) ? r.hi.y : r.lo.y;
          pv.z = (planes[k].nz >= 0) ? r.hi.z : r.lo.z;
          nv.x = (planes[k].nx >= 0) ? r.lo.x : r.hi.x;
          nv.y = (planes[k].ny >= 0) ? r.lo.y : r.hi.y;
          nv.z = (planes[k].nz >= 0) ? r.lo.z : r.hi.z;
          if (behind_plane(k, pv)) any_out = 1;
          else if (behind_plane(k, nv)) any_cut = 1;
        end
        if (any_out) v = fac_pkg::VerdictOutside;
        else if (any_cut) v = fac_pkg::VerdictIntersect;
        else v = fac_pkg::VerdictInside;
        verdicts_due.push_back(v);
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      fac_pkg::verdict_e want;
      if (verdicts_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("ERROR: unexpected verdict %0d", got);
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: verdict expected %0d (%s) got %0d", want, want.name(), got);
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  int unsigned  tx_idle_pct;
  int unsigned  rx_stall_pct;
  cull_checker  sb;

  fac_req_if req ();
  fac_rsp_if rsp ();

  frustum_aabb_cull uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("frustum_aabb_cull verification failed");
    $finish;
  end

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_req
    cull_req_t seen;
    if (rst_ni && req.valid && req.ready) begin
      seen.op  = req.operation;
      seen.idx = req.plane_index;
      seen.pl  = '{req.normal_x, req.normal_y, req.normal_z, req.plane_offset};
      seen.lo  = '{req.low_x, req.low_y, req.low_z};
      seen.hi  = '{req.high_x, req.high_y, req.high_z};
      sb.note_request(seen);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_verdict(rsp.verdict);
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return Max;
          1: return Min;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_normal();
    if ($urandom_range(3) == 0) return rand_coord();
    return $signed($urandom_range(32'h0002_0000)) - One;
  endfunction

  function automatic cull_req_t make_req(logic [1:0] op, logic [fac_pkg::PlaneIdxW-1:0] idx,
                                         fac_pkg::plane_t pl, fac_pkg::vec_t lo,
                                         fac_pkg::vec_t hi);
    cull_req_t r;
    r.op  = op;
    r.idx = idx;
    r.pl  = pl;
    r.lo  = lo;
    r.hi  = hi;
    return r;
  endfunction

  function automatic cull_req_t random_request();
    cull_req_t   r;
    int unsigned pick;
    r.idx = fac_pkg::PlaneIdxW'($urandom_range(7));
    r.pl  = '{rand_normal(), rand_normal(), rand_normal(), rand_coord()};
    r.lo  = '{rand_coord(), rand_coord(), rand_coord()};
    if ($urandom_range(7) == 0) begin
      r.hi = '{rand_coord(), rand_coord(), rand_coord()};
    end else begin
      r.hi.x = r.lo.x + $signed($urandom_range(32'h0004_0000));
      r.hi.y = r.lo.y + $signed($urandom_range(32'h0004_0000));
      r.hi.z = r.lo.z + $signed($urandom_range(32'h0004_0000));
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.op  = fac_pkg::OpWrite;
      r.idx = fac_pkg::PlaneIdxW'($urandom_range(fac_pkg::NumPlanes - 1));
    end else if (pick < 10) begin
      r.op = fac_pkg::OpWrite;
    end else if (pick < 12) begin
      r.op = OpUnused;
    end else if (pick < 45) begin
      r.op = fac_pkg::OpPoint;
    end else begin
      r.op = fac_pkg::OpBox;
    end
    return r;
  endfunction

  task automatic send_request(cull_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.operation    <= r.op;
    req.plane_index  <= r.idx;
    req.normal_x     <= r.pl.nx;
    req.normal_y     <= r.pl.ny;
    req.normal_z     <= r.pl.nz;
    req.plane_offset <= r.pl.d;
    req.low_x        <= r.lo.x;
    req.low_y        <= r.lo.y;
    req.low_z        <= r.lo.z;
    req.high_x       <= r.hi.x;
    req.high_y       <= r.hi.y;
    req.high_z       <= r.hi.z;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    cull_req_t       r;
    int unsigned     counted;
    fac_pkg::plane_t zero_pl;
    fac_pkg::vec_t   zero_v;
    int unsigned     phase_tx[4] = '{0, 86, 0, 6};
    int unsigned     phase_rx[4] = '{0, 0, 86, 6};
    sb = new();
    zero_pl = '0;
    zero_v  = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst_ni           <= 1'b0;
    req.valid        <= 1'b0;
    req.operation    <= fac_pkg::OpWrite;
    req.plane_index  <= '0;
    req.normal_x     <= '0;
    req.normal_y     <= '0;
    req.normal_z     <= '0;
    req.plane_offset <= '0;
    req.low_x        <= '0;
    req.low_y        <= '0;
    req.low_z        <= '0;
    req.high_x       <= '0;
    req.high_y       <= '0;
    req.high_z       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every plane is zero and culls nothing.
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, '{Min, Min, Min}, zero_v));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, '{Min, Min, Min},
                          '{Max, Max, Max}));
    send_request(make_req(fac_pkg::OpWrite, 3'd0, '{Max, Min, 32'sd0, Min}, zero_v, zero_v));
    send_request(make_req(fac_pkg::OpWrite, 3'd5, '{Min, Max, -32'sd1, Max}, zero_v, zero_v));
    send_request(make_req(fac_pkg::OpWrite, 3'd6, '{One, One, One, Min}, zero_v, zero_v));
    send_request(make_req(fac_pkg::OpWrite, 3'd7, '{One, One, One, Min}, zero_v, zero_v));
    send_request(make_req(OpUnused, 3'd7, '{Max, Max, Max, Max}, '{Max, Max, Max},
                          '{Max, Max, Max}));
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, '{Max, Max, Max}, zero_v));
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, '{Min, Min, Min}, zero_v));
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, zero_v, zero_v));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, '{Min, Min, Min},
                          '{Max, Max, Max}));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, '{Max, Max, Max},
                          '{Min, Min, Min}));
    // A single plane x >= 1.0 makes zero distance reachable.
    send_request(make_req(fac_pkg::OpWrite, 3'd0, '{One, 32'sd0, 32'sd0, -One}, zero_v,
                          zero_v));
    send_request(make_req(fac_pkg::OpWrite, 3'd5, zero_pl, zero_v, zero_v));
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, '{One, 32'sd0, 32'sd0}, zero_v));
    send_request(make_req(fac_pkg::OpPoint, 3'd0, zero_pl, '{One - 1, 32'sd0, 32'sd0},
                          zero_v));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, zero_v,
                          '{2 * One, 2 * One, 2 * One}));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, '{One, One, One},
                          '{2 * One, 2 * One, 2 * One}));
    send_request(make_req(fac_pkg::OpBox, 3'd0, zero_pl, '{-2 * One, -2 * One, -2 * One},
                          '{One - 1, One - 1, One - 1}));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      // Start each phase from a cube frustum of half size four around the origin.
      for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
        r = make_req(fac_pkg::OpWrite, fac_pkg::PlaneIdxW'(k), '0, zero_v, zero_v);
        case (k / 2)
          0: r.pl.nx = (k % 2) ? -One : One;
          1: r.pl.ny = (k % 2) ? -One : One;
          default: r.pl.nz = (k % 2) ? -One : One;
        endcase
        r.pl.d = 4 * One;
        send_request(r);
      end
      counted = 0;
      while (counted < ItemsPerPhase) begin
        r = random_request();
        send_request(r);
        if (r.op != OpUnused && !(r.op == fac_pkg::OpWrite && r.idx >= fac_pkg::NumPlanes))
          counted++;
      end
      if (ph == 1) drain();
    end

    drain();
    if (sb.faults == 0) begin
      $display("frustum_aabb_cull verification clean");
    end else begin
      $display("frustum_aabb_cull verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/fac_pkg.sv
rtl/fac_if.sv
rtl/fac_plane_eval.sv
rtl/frustum_aabb_cull.sv
sim/tb_top.sv
